// File: sv/smstep_pkg.sv
// Shared types and constants for the stack machine step block.
// No dependencies; every file but smstep_if and smstep_div imports this package.
`timescale 1ns / 1ps
`default_nettype none

package smstep_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int REG_COUNT_DEF   = 16;

    localparam logic [7:0] PROG_LEN_RESET  = 8'd255;
    localparam logic [7:0] UNDERFLOW_VALUE = 8'hFF;

    localparam logic [2:0] LEN_SHORT = 3'd1;
    localparam logic [2:0] LEN_WORD  = 3'd2;
    localparam logic [2:0] LEN_COND  = 3'd4;

    typedef enum logic [3:0] {
        ACT_PUSH    = 4'd0,
        ACT_POP     = 4'd1,
        ACT_ADD     = 4'd2,
        ACT_MUL     = 4'd3,
        ACT_SUB     = 4'd4,
        ACT_DIV     = 4'd5,
        ACT_PUSHREG = 4'd6,
        ACT_POPREG  = 4'd7,
        ACT_JMP     = 4'd8,
        ACT_JE      = 4'd9,
        ACT_JNE     = 4'd10,
        ACT_JA      = 4'd11,
        ACT_JAE     = 4'd12,
        ACT_JB      = 4'd13,
        ACT_JBE     = 4'd14,
        ACT_END     = 4'd15
    } action_t;

    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_OVERFLOW     = 3'd1,
        ERR_UNDERFLOW    = 3'd2,
        ERR_DIV_ZERO     = 3'd3,
        ERR_BAD_JUMP     = 3'd4,
        ERR_POPREG_EMPTY = 3'd5
    } error_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic div_start;
        logic commit;
    } smstep_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } smstep_status_t;

endpackage

`default_nettype wire

// File: sv/smstep_if.sv
// Valid/ready channel interfaces for instruction requests and results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface smstep_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    logic signed [7:0] immediate;
    logic [3:0]        first_reg;
    logic [3:0]        second_reg;
    logic signed [7:0] target;

    modport source (
        output valid, action, immediate, first_reg, second_reg, target,
        input  ready
    );
    modport sink (
        input  valid, action, immediate, first_reg, second_reg, target,
        output ready
    );
endinterface

interface smstep_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        next_pc;
    logic signed [7:0] popped_value;
    logic              popped_valid;
    logic [2:0]        error_code;
    logic              halted;

    modport source (
        output valid, next_pc, popped_value, popped_valid, error_code, halted,
        input  ready
    );
    modport sink (
        input  valid, next_pc, popped_value, popped_valid, error_code, halted,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/smstep_div.sv
// Iterative 8-bit signed divider, one quotient bit per cycle, truncating.
// Standalone; used by smstep_datapath.
`timescale 1ns / 1ps
`default_nettype none

module smstep_div (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [7:0] dividend,
    input  wire logic [7:0] divisor,
    output logic            done,
    output logic [7:0]      quotient
);

    localparam logic [2:0] LAST_STEP = 3'd7;

    logic       busy_reg;
    logic       done_reg;
    logic [2:0] step_reg;
    logic [8:0] rem_reg;
    logic [7:0] quo_reg;
    logic [7:0] dvs_reg;
    logic       neg_reg;

    logic [7:0] dvd_mag;
    logic [7:0] dvs_mag;
    logic [8:0] rem_shift;
    logic       fits;
    logic [8:0] rem_new;

    assign dvd_mag   = dividend[7] ? 8'(-dividend) : dividend;
    assign dvs_mag   = divisor[7]  ? 8'(-divisor)  : divisor;
    assign rem_shift = {rem_reg[7:0], quo_reg[7]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_new   = fits ? rem_shift - {1'b0, dvs_reg} : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dvd_mag;
            dvs_reg <= dvs_mag;
            neg_reg <= dividend[7] ^ divisor[7];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            quo_reg <= {quo_reg[6:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 8'(-quo_reg) : quo_reg;

endmodule

`default_nettype wire

// File: sv/smstep_datapath.sv
// Datapath: stack and register memories, pc, halt flag, result register.
// Depends on smstep_pkg and smstep_div.
`timescale 1ns / 1ps
`default_nettype none

module smstep_datapath
    import smstep_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire smstep_cmd_t       cmd,
    output smstep_status_t         status,
    input  wire logic [3:0]        action,
    input  wire logic signed [7:0] immediate,
    input  wire logic [3:0]        first_reg,
    input  wire logic [3:0]        second_reg,
    input  wire logic signed [7:0] target,
    input  wire logic              cfg_wr_en,
    input  wire logic [7:0]        cfg_wr_data,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [7:0]             next_pc,
    output logic signed [7:0]      popped_value,
    output logic                   popped_valid,
    output logic [2:0]             error_code,
    output logic                   halted
);

    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int RIW = $clog2(REG_COUNT);

    logic [7:0] stack_mem [STACK_DEPTH];
    logic [7:0] reg_mem   [REG_COUNT];

    // request fields
    action_t           act_reg;
    logic signed [7:0] imm_reg;
    logic [3:0]        r1_reg;
    logic [3:0]        r2_reg;
    logic signed [7:0] tgt_reg;

    // operand read data
    logic [7:0] top_rd_reg;
    logic [7:0] nxt_rd_reg;
    logic [7:0] r1_rd_reg;
    logic [7:0] r2_rd_reg;
    logic       r1_ok_reg;
    logic       r2_ok_reg;

    // architectural state
    logic [CW-1:0]        count_reg;
    logic [7:0]           pc_reg;
    logic                 halt_reg;
    logic [7:0]           prog_len_reg;
    logic [REG_COUNT-1:0] reg_valid_reg;

    // result register
    logic              out_valid_reg;
    logic [7:0]        next_pc_reg;
    logic signed [7:0] popped_value_reg;
    logic              popped_valid_reg;
    error_t            error_reg;
    logic              halted_reg;

    logic [CW-1:0]  count_m1;
    logic [CW-1:0]  count_m2;
    logic [SIW-1:0] top_addr;
    logic [SIW-1:0] nxt_addr;
    logic [31:0]    r1_wide;
    logic [31:0]    r2_wide;
    logic [RIW-1:0] r1_addr;
    logic [RIW-1:0] r2_addr;
    logic           r1_in;
    logic           r2_in;
    logic           c_ge1;
    logic           c_ge2;
    logic [7:0]     opa;
    logic [7:0]     opb;
    logic [7:0]     r1_val;
    logic [7:0]     r2_val;
    logic [15:0]    prod_full;
    logic [7:0]     div_q;
    logic           div_done;
    logic           bad_target;

    logic           push_en;
    logic [CW-1:0]  push_addr;
    logic [7:0]     push_data;
    logic [CW-1:0]  count_next;
    logic           reg_we;
    logic [7:0]     pc_next;
    logic           halt_next;
    logic [7:0]     popped_next;
    logic           pvalid_next;
    error_t         err_next;
    logic [2:0]     len;
    logic           jumping;
    logic           stay;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign top_addr = count_m1[SIW-1:0];
    assign nxt_addr = count_m2[SIW-1:0];
    assign r1_wide  = 32'(r1_reg);
    assign r2_wide  = 32'(r2_reg);
    assign r1_addr  = r1_wide[RIW-1:0];
    assign r2_addr  = r2_wide[RIW-1:0];
    assign r1_in    = r1_wide < 32'(REG_COUNT);
    assign r2_in    = r2_wide < 32'(REG_COUNT);

    // missing stack operands read as -1
    assign c_ge1     = count_reg != '0;
    assign c_ge2     = count_reg >= CW'(2);
    assign opa       = c_ge1 ? top_rd_reg : UNDERFLOW_VALUE;
    assign opb       = c_ge2 ? nxt_rd_reg : UNDERFLOW_VALUE;
    assign r1_val    = r1_ok_reg ? r1_rd_reg : 8'd0;
    assign r2_val    = r2_ok_reg ? r2_rd_reg : 8'd0;
    assign prod_full = {8'd0, opb} * {8'd0, opa};
    assign bad_target = tgt_reg[7] || (tgt_reg[7:0] > prog_len_reg);

    smstep_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (opb),
        .divisor  (opa),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.need_div = !halt_reg && (act_reg == ACT_DIV) && (opa != 8'd0);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        push_en     = 1'b0;
        push_addr   = count_reg;
        push_data   = imm_reg;
        count_next  = count_reg;
        reg_we      = 1'b0;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        popped_next = 8'd0;
        pvalid_next = 1'b0;
        err_next    = ERR_OK;
        len         = LEN_SHORT;
        jumping     = 1'b0;
        stay        = 1'b0;
        if (!halt_reg)
        begin
            unique case (act_reg) inside
                ACT_PUSH, ACT_PUSHREG:
                begin
                    len       = LEN_WORD;
                    push_data = (act_reg == ACT_PUSH) ? imm_reg : r1_val;
                    if (count_reg < CW'(STACK_DEPTH))
                    begin
                        push_en    = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                end
                ACT_POP:
                begin
                    pvalid_next = 1'b1;
                    popped_next = opa;
                    if (c_ge1)
                    begin
                        count_next = count_m1;
                    end
                    else
                    begin
                        err_next = ERR_UNDERFLOW;
                    end
                end
                ACT_ADD, ACT_MUL, ACT_SUB, ACT_DIV:
                begin
                    push_addr = c_ge2 ? count_m2 : '0;
                    if (!c_ge2)
                    begin
                        err_next = ERR_UNDERFLOW;
                    end
                    if (act_reg == ACT_DIV && opa == 8'd0)
                    begin
                        err_next   = ERR_DIV_ZERO;
                        count_next = push_addr;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        count_next = push_addr + CW'(1);
                        case (act_reg)
                            ACT_ADD: push_data = opb + opa;
                            ACT_MUL: push_data = prod_full[7:0];
                            ACT_SUB: push_data = opb - opa;
                            default: push_data = div_q;
                        endcase
                    end
                end
                ACT_POPREG:
                begin
                    len = LEN_WORD;
                    if (c_ge1)
                    begin
                        count_next = count_m1;
                        reg_we     = r1_in;
                    end
                    else
                    begin
                        err_next = ERR_POPREG_EMPTY;
                    end
                end
                ACT_JMP:
                begin
                    len     = LEN_WORD;
                    jumping = 1'b1;
                end
                ACT_END:
                begin
                    halt_next = 1'b1;
                    stay      = 1'b1;
                end
                ACT_JE:  begin len = LEN_COND; jumping = r1_val == r2_val; end
                ACT_JNE: begin len = LEN_COND; jumping = r1_val != r2_val; end
                ACT_JA:  begin len = LEN_COND; jumping = $signed(r1_val) >  $signed(r2_val); end
                ACT_JAE: begin len = LEN_COND; jumping = $signed(r1_val) >= $signed(r2_val); end
                ACT_JB:  begin len = LEN_COND; jumping = $signed(r1_val) <  $signed(r2_val); end
                ACT_JBE: begin len = LEN_COND; jumping = $signed(r1_val) <= $signed(r2_val); end
                default: ;
            endcase
            if (jumping)
            begin
                if (bad_target)
                begin
                    err_next  = ERR_BAD_JUMP;
                    halt_next = 1'b1;
                end
                else
                begin
                    pc_next = tgt_reg;
                end
            end
            else if (!stay)
            begin
                pc_next = pc_reg + {5'd0, len};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            prog_len_reg  <= PROG_LEN_RESET;
            reg_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prog_len_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                pc_reg    <= pc_next;
                halt_reg  <= halt_next;
                if (reg_we)
                begin
                    reg_valid_reg[r1_addr] <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action_t'(action);
            imm_reg <= immediate;
            r1_reg  <= first_reg;
            r2_reg  <= second_reg;
            tgt_reg <= target;
        end
        if (cmd.fetch)
        begin
            top_rd_reg <= stack_mem[top_addr];
            nxt_rd_reg <= stack_mem[nxt_addr];
            r1_rd_reg  <= reg_mem[r1_addr];
            r2_rd_reg  <= reg_mem[r2_addr];
            r1_ok_reg  <= r1_in && reg_valid_reg[r1_addr];
            r2_ok_reg  <= r2_in && reg_valid_reg[r2_addr];
        end
        if (cmd.commit)
        begin
            if (push_en)
            begin
                stack_mem[push_addr[SIW-1:0]] <= push_data;
            end
            if (reg_we)
            begin
                reg_mem[r1_addr] <= opa;
            end
            next_pc_reg      <= pc_next;
            popped_value_reg <= popped_next;
            popped_valid_reg <= pvalid_next;
            error_reg        <= err_next;
            halted_reg       <= halt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = next_pc_reg;
    assign popped_value = popped_value_reg;
    assign popped_valid = popped_valid_reg;
    assign error_code   = error_reg;
    assign halted       = halted_reg;

endmodule

`default_nettype wire

// File: sv/smstep_ctrl.sv
// Controller: sequences capture, operand fetch, divide and commit.
// Depends on smstep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smstep_ctrl
    import smstep_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire smstep_status_t status,
    output smstep_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OPER,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_OPER;
                end
                ST_OPER:
                begin
                    state_reg <= status.need_div ? ST_DIVIDE : ST_DONE;
                end
                ST_DIVIDE:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = state_reg == ST_IDLE;
    assign cmd.capture   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.fetch     = state_reg == ST_FETCH;
    assign cmd.div_start = (state_reg == ST_OPER) && status.need_div;
    assign cmd.commit    = (state_reg == ST_DONE) && status.out_free;

endmodule

`default_nettype wire

// File: sv/stack_machine_step_top.sv
// Top level of the stack machine step block: controller plus datapath.
// Depends on smstep_pkg, smstep_if, smstep_ctrl, smstep_datapath.
//
//  channel  | kind            | handshake      | content
//  ---------+-----------------+----------------+-------------------------------
//  instr    | request in      | valid/ready    | action, immediate, regs, target
//  result   | result out      | valid/ready    | next_pc, popped value, error
//  cfg      | register write  | cfg_wr_en      | program_length
//
// A request passes the fetch, operand and done states before the next is accepted;
// a divide also waits in the divide state for the bit-serial divider (8 steps).
// Operands are read from the stack and register memories into registers in the fetch state.
// A finished result sits in the output register while the next request is taken;
// only a commit into a still-occupied output register stalls.
// Reset is asynchronous; all state is ready after reset, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_step_top
    import smstep_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    smstep_in_if.sink       instr,
    smstep_out_if.source    result,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    smstep_cmd_t    cmd;
    smstep_status_t status;

    smstep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .status   (status),
        .cmd      (cmd)
    );

    smstep_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (instr.action),
        .immediate    (instr.immediate),
        .first_reg    (instr.first_reg),
        .second_reg   (instr.second_reg),
        .target       (instr.target),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .next_pc      (result.next_pc),
        .popped_value (result.popped_value),
        .popped_valid (result.popped_valid),
        .error_code   (result.error_code),
        .halted       (result.halted)
    );

    a_one_request_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        instr.valid && instr.ready |=> !instr.ready)
        else $error("request accepted while previous one still in flight");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result.valid)
        else $error("commit did not load the result register");

    a_divide_takes_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.commit && !instr.ready)
        else $error("commit or accept right after divider start");

endmodule

`default_nettype wire

// File: verif/smstep_checker.sv
// Checker for the stack machine step block: watches the request, result and
// register-write ports, predicts each result and compares it field by field.
// Depends on smstep_pkg and smstep_if.
`timescale 1ns / 1ps

module smstep_checker
    import smstep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    smstep_in_if            instr,
    smstep_out_if           result,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    output int              failures,
    output int              pending
);

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int REG_COUNT   = REG_COUNT_DEF;

    typedef struct packed {
        logic [7:0]        next_pc;
        logic signed [7:0] popped_value;
        logic              popped_valid;
        logic [2:0]        error_code;
        logic              halted;
    } step_result_t;

    logic signed [7:0] stack_mem [STACK_DEPTH];
    int                stack_used;
    logic signed [7:0] reg_mem [REG_COUNT];
    logic [7:0]        pc;
    logic              halt;
    logic [7:0]        jump_limit;

    step_result_t expected_results[$];

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    function automatic bit model_push(logic signed [7:0] v);
        if (stack_used >= STACK_DEPTH)
            return 1'b0;
        stack_mem[stack_used] = v;
        stack_used++;
        return 1'b1;
    endfunction

    function automatic bit model_pop(output logic signed [7:0] v);
        v = '0;
        if (stack_used == 0)
            return 1'b0;
        stack_used--;
        v = stack_mem[stack_used];
        stack_mem[stack_used] = '0;
        return 1'b1;
    endfunction

    function automatic step_result_t execute_instr(action_t act, logic signed [7:0] imm,
                                                   logic [3:0] ra, logic [3:0] rb,
                                                   logic signed [7:0] tgt);
        step_result_t      res;
        logic signed [7:0] a, b, v, p, q;
        int                x, y, acc, len, t, lim;
        bit                jumping, stay;
        error_t            err;
        res          = '0;
        err          = ERR_OK;
        len          = LEN_SHORT;
        jumping      = 1'b0;
        stay         = 1'b0;
        acc          = 0;
        if (!halt)
        begin
            case (act)
                ACT_PUSH:
                begin
                    len = LEN_WORD;
                    if (!model_push(imm))
                        err = ERR_OVERFLOW;
                end
                ACT_POP:
                begin
                    res.popped_valid = 1'b1;
                    if (!model_pop(v))
                    begin
                        v   = UNDERFLOW_VALUE;
                        err = ERR_UNDERFLOW;
                    end
                    res.popped_value = v;
                end
                ACT_ADD, ACT_MUL, ACT_SUB, ACT_DIV:
                begin
                    if (!model_pop(a))
                    begin
                        a   = UNDERFLOW_VALUE;
                        err = ERR_UNDERFLOW;
                    end
                    if (!model_pop(b))
                    begin
                        b   = UNDERFLOW_VALUE;
                        err = ERR_UNDERFLOW;
                    end
                    y = a;
                    x = b;
                    if (act == ACT_DIV && y == 0)
                        err = ERR_DIV_ZERO;
                    else
                    begin
                        case (act)
                            ACT_ADD: acc = x + y;
                            ACT_MUL: acc = x * y;
                            ACT_SUB: acc = x - y;
                            default: acc = x / y;
                        endcase
                        if (!model_push(acc[7:0]))
                            err = ERR_OVERFLOW;
                    end
                end
                ACT_PUSHREG:
                begin
                    len = LEN_WORD;
                    if (!model_push(ra < REG_COUNT ? reg_mem[ra] : 8'sd0))
                        err = ERR_OVERFLOW;
                end
                ACT_POPREG:
                begin
                    len = LEN_WORD;
                    if (model_pop(v))
                    begin
                        if (ra < REG_COUNT)
                            reg_mem[ra] = v;
                    end
                    else
                        err = ERR_POPREG_EMPTY;
                end
                ACT_JMP:
                begin
                    len     = LEN_WORD;
                    jumping = 1'b1;
                end
                ACT_END:
                begin
                    halt = 1'b1;
                    stay = 1'b1;
                end
                default:
                begin
                    len = LEN_COND;
                    p   = ra < REG_COUNT ? reg_mem[ra] : 8'sd0;
                    q   = rb < REG_COUNT ? reg_mem[rb] : 8'sd0;
                    case (act)
                        ACT_JE:  jumping = (p == q);
                        ACT_JNE: jumping = (p != q);
                        ACT_JA:  jumping = (p > q);
                        ACT_JAE: jumping = (p >= q);
                        ACT_JB:  jumping = (p < q);
                        default: jumping = (p <= q);
                    endcase
                end
            endcase

            t   = tgt;
            lim = jump_limit;
            if (jumping)
            begin
                if (t < 0 || t > lim)
                begin
                    err  = ERR_BAD_JUMP;
                    halt = 1'b1;
                end
                else
                    pc = tgt;
            end
            else if (!stay)
                pc = 8'(pc + len);
        end
        res.next_pc    = pc;
        res.error_code = err;
        res.halted     = halt;
        return res;
    endfunction

    function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
                stack_mem[i] = '0;
            for (int i = 0; i < REG_COUNT; i++)
                reg_mem[i] = '0;
            stack_used = 0;
            pc         = '0;
            halt       = 1'b0;
            jump_limit = PROG_LEN_RESET;
            expected_results.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                jump_limit = cfg_wr_data;
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, next_pc %0h error %0h", $time,
                             result.next_pc, result.error_code);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("next_pc", want.next_pc, result.next_pc);
                    report_field("popped_value", want.popped_value, result.popped_value);
                    report_field("popped_valid", want.popped_valid, result.popped_valid);
                    report_field("error_code", want.error_code, result.error_code);
                    report_field("halted", want.halted, result.halted);
                end
            end
            if (instr.valid && instr.ready)
                expected_results.push_back(execute_instr(action_t'(instr.action),
                                                         instr.immediate, instr.first_reg,
                                                         instr.second_reg, instr.target));
            pending = expected_results.size();
        end
    end

endmodule

// File: verif/stack_machine_step_top_test.sv
// Testbench top for stack_machine_step_top: clock, reset, request stimulus,
// result back-pressure and program_length writes; verdict from smstep_checker.
// Depends on smstep_pkg, smstep_if, smstep_checker and the block's RTL.
`timescale 1ns / 1ps

module stack_machine_step_top_test;
    import smstep_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    int         failures;
    int         pending;
    logic [7:0] prog_len;
    bit         in_burst;
    bit         out_burst;

    smstep_in_if  instr ();
    smstep_out_if result ();

    stack_machine_step_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr       (instr),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    smstep_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr       (instr),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .failures    (failures),
        .pending     (pending)
    );

    initial
        clk = 1'b0;

    always
        #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // result back-pressure
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 14);
            repeat (stall)
            begin
                @(negedge clk);
                result.ready <= 1'b0;
            end
            @(negedge clk);
            result.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result.valid && result.ready));
        end
    end

    task automatic send_instr(action_t act, logic signed [7:0] imm = 0,
                              logic [3:0] ra = 0, logic [3:0] rb = 0,
                              logic signed [7:0] tgt = 0);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            @(negedge clk);
            instr.valid <= 1'b0;
        end
        @(negedge clk);
        instr.valid      <= 1'b1;
        instr.action     <= act;
        instr.immediate  <= imm;
        instr.first_reg  <= ra;
        instr.second_reg <= rb;
        instr.target     <= tgt;
        do
            @(posedge clk);
        while (!(instr.valid && instr.ready));
    endtask

    task automatic drain();
        @(negedge clk);
        instr.valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_length(logic [7:0] len);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        prog_len     = len;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [7:0] legal_target();
        int hi;
        hi = prog_len > 127 ? 127 : prog_len;
        if ($urandom_range(0, 7) == 0)
            return 8'(hi);
        return 8'($urandom_range(0, hi));
    endfunction

    task automatic send_random_instr(int push_pct);
        int                pick;
        action_t           act;
        logic signed [7:0] imm;
        logic signed [7:0] tgt;
        logic [3:0]        ra;
        logic [3:0]        rb;
        pick = $urandom_range(0, 99);
        imm  = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 3))
                0:       imm = 0;
                1:       imm = -1;
                2:       imm = 127;
                default: imm = -128;
            endcase
        ra  = 4'($urandom);
        rb  = 4'($urandom);
        tgt = legal_target();
        if (pick < push_pct)
            act = ($urandom_range(0, 3) == 0) ? ACT_PUSHREG : ACT_PUSH;
        else if (pick < 80)
            case ($urandom_range(0, 9))
                0, 1, 2: act = ACT_POP;
                3, 4, 5: act = ACT_POPREG;
                default: act = action_t'($urandom_range(int'(ACT_ADD), int'(ACT_DIV)));
            endcase
        else
        begin
            act = action_t'($urandom_range(int'(ACT_JMP), int'(ACT_JBE)));
            // same register on both sides fixes the outcome; untaken ones take any target
            if (act != ACT_JMP && $urandom_range(0, 2) == 0)
            begin
                rb = ra;
                if (act inside {ACT_JNE, ACT_JA, ACT_JB})
                    tgt = 8'($urandom);
            end
        end
        send_instr(act, imm, ra, rb, tgt);
    endtask

    initial
    begin
        logic [7:0]        lengths [8];
        int                push_mix [3];
        logic signed [7:0] bad_tgt;
        lengths  = '{8'd0, 8'd100, 8'd127, 8'd255, 8'd1, 8'd128, 8'd64, 8'd0};
        push_mix = '{60, 20, 35};
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        prog_len         = PROG_LEN_RESET;
        in_burst         = 1'b0;
        out_burst        = 1'b0;
        instr.valid      = 1'b0;
        instr.action     = ACT_PUSH;
        instr.immediate  = '0;
        instr.first_reg  = '0;
        instr.second_reg = '0;
        instr.target     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_length(8'd255);
        send_instr(ACT_POP);
        send_instr(ACT_ADD);
        send_instr(ACT_POPREG, 0, 4'd3);
        send_instr(ACT_POPREG, 0, 4'd4);
        send_instr(ACT_PUSH, 127);
        send_instr(ACT_PUSH, 1);
        send_instr(ACT_ADD);
        send_instr(ACT_PUSH, -1);
        send_instr(ACT_DIV);
        send_instr(ACT_PUSH, 0);
        send_instr(ACT_DIV);
        send_instr(ACT_PUSH, 0);
        send_instr(ACT_DIV);
        send_instr(ACT_PUSH, -128);
        send_instr(ACT_PUSH, -128);
        send_instr(ACT_MUL);
        send_instr(ACT_SUB);
        send_instr(ACT_PUSHREG, 0, 4'd3);
        send_instr(ACT_JMP, 0, 0, 0, 100);
        send_instr(ACT_JE, 0, 4'd0, 4'd4, 0);
        send_instr(ACT_JNE, 0, 4'd3, 4'd3, -128);
        send_instr(ACT_JA, 0, 4'd3, 4'd0, 50);
        send_instr(ACT_JB, 0, 4'd3, 4'd0, 127);
        send_instr(ACT_JAE, 0, 4'd0, 4'd3, 7);
        send_instr(ACT_JBE, 0, 4'd0, 4'd3, 9);
        drain();

        for (int i = 0; i < 8; i++)
        begin
            in_burst  = (i % 4 == 1) || (i == 6);
            out_burst = (i % 4 == 2) || (i == 6);
            write_length(i == 5 ? 8'($urandom_range(0, 255)) : lengths[i]);
            repeat (160)
                send_random_instr(push_mix[i % 3]);
            drain();
        end

        // halting step last, then requests the stopped machine must ignore
        in_burst  = 1'b0;
        out_burst = 1'b0;
        write_length(8'($urandom_range(0, 127)));
        if ($urandom_range(0, 1) == 0)
            send_instr(ACT_END, 8'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
        else
        begin
            if (prog_len < 127 && $urandom_range(0, 1) == 0)
                bad_tgt = 8'($urandom_range(int'(prog_len) + 1, 127));
            else
                bad_tgt = 8'(-$urandom_range(1, 128));
            if ($urandom_range(0, 1) == 0)
                send_instr(ACT_JMP, 8'($urandom), 4'($urandom), 4'($urandom), bad_tgt);
            else
                send_instr(ACT_JBE, 8'($urandom), 4'd5, 4'd5, bad_tgt);
        end
        repeat (4)
            send_instr(action_t'($urandom_range(0, 15)), 8'($urandom), 4'($urandom),
                       4'($urandom), 8'($urandom));
        drain();

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
